@@ sv/hhdf_pkg.sv @@
package hhdf_pkg;

   // Field widths fixed by the point format
   localparam int COORD_W = 24;
   localparam int COUNT_W = 16;
   localparam int CSR_W   = 16;
   localparam int OP_W    = 2;

   // Operation codes
   localparam logic [OP_W-1:0] OP_COUNT  = 2'd0;
   localparam logic [OP_W-1:0] OP_FILTER = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

   // Register indexes
   localparam logic CSR_THRESHOLD = 1'b0;
   localparam logic CSR_BASE      = 1'b1;

   localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;
   localparam logic [CSR_W-1:0]   THRESHOLD_RESET = 16'd20;

   typedef logic [OP_W-1:0] op_type;

   // Controller to datapath
   typedef struct packed {
      logic load_item;
      logic calc_bin;
      logic read_bin;
      logic write_bin;
      logic load_out;
      logic clear_start;
      logic clear_en;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      op_type op;
      logic   in_range;
      logic   count_sat;
      logic   keep;
      logic   clear_last;
      logic   out_busy;
   } status_type;

endpackage

@@ sv/hhdf_req_if.sv @@
interface hhdf_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [hhdf_pkg::OP_W-1:0]              op;
   logic signed [hhdf_pkg::COORD_W-1:0]    coord_x;
   logic signed [hhdf_pkg::COORD_W-1:0]    coord_y;
   logic signed [hhdf_pkg::COORD_W-1:0]    coord_z;

   modport source (output valid, op, coord_x, coord_y, coord_z, input ready);
   modport sink (input valid, op, coord_x, coord_y, coord_z, output ready);
endinterface

@@ sv/hhdf_rsp_if.sv @@
interface hhdf_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [hhdf_pkg::COORD_W-1:0]    kept_x;
   logic signed [hhdf_pkg::COORD_W-1:0]    kept_y;
   logic signed [hhdf_pkg::COORD_W-1:0]    kept_z;

   modport source (output valid, kept_x, kept_y, kept_z, input ready);
   modport sink (input valid, kept_x, kept_y, kept_z, output ready);
endinterface

@@ sv/hhdf_ctrl.sv @@
module hhdf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  hhdf_pkg::op_type     req_op,
   output logic                 req_ready,
   input  hhdf_pkg::status_type status,
   output hhdf_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_BIN,
      ST_READ,
      ST_UPDATE
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_ready && req_valid;

   // Decode commands and next state
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               cmd.load_item = 1'b1;
               if (req_op == hhdf_pkg::OP_CLEAR) begin
                  cmd.clear_start = 1'b1;
                  state_in        = ST_CLEAR;
               end else if (req_op == hhdf_pkg::OP_COUNT ||
                            req_op == hhdf_pkg::OP_FILTER) begin
                  state_in = ST_BIN;
               end
            end
         end
         ST_BIN: begin
            cmd.calc_bin = 1'b1;
            state_in     = ST_READ;
         end
         ST_READ: begin
            cmd.read_bin = 1'b1;
            state_in     = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = ST_IDLE;
            if (status.in_range) begin
               if (status.op == hhdf_pkg::OP_COUNT) begin
                  cmd.write_bin = !status.count_sat;
               end else if (status.keep) begin
                  // hold until the output register frees up
                  if (status.out_busy) state_in = ST_UPDATE;
                  else cmd.load_out = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else state_ff <= state_in;
   end

endmodule

@@ sv/hhdf_datapath.sv @@
module hhdf_datapath #(
   parameter int NUM_BINS  = 256,
   parameter int FRAC_BITS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  hhdf_pkg::cmd_type                     cmd,
   output hhdf_pkg::status_type                  status,
   input  hhdf_pkg::op_type                      req_op,
   input  logic signed [hhdf_pkg::COORD_W-1:0]   req_x,
   input  logic signed [hhdf_pkg::COORD_W-1:0]   req_y,
   input  logic signed [hhdf_pkg::COORD_W-1:0]   req_z,
   input  logic                                  csr_write,
   input  logic                                  csr_index,
   input  logic [hhdf_pkg::CSR_W-1:0]            csr_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [hhdf_pkg::COORD_W-1:0]   rsp_x,
   output logic signed [hhdf_pkg::COORD_W-1:0]   rsp_y,
   output logic signed [hhdf_pkg::COORD_W-1:0]   rsp_z
);

   localparam int IDX_W = $clog2(NUM_BINS);
   localparam int CW    = hhdf_pkg::COORD_W;
   localparam int MAG_W = CW + 1;        // magnitude plus rounding carry
   localparam int HGT_W = MAG_W + 1;     // signed rounded height
   localparam int BIN_W = HGT_W + 1;     // height minus base, no wrap
   localparam logic [MAG_W-1:0] HALF =
      (FRAC_BITS == 0) ? '0 : MAG_W'(1) << (FRAC_BITS - 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BINS - 1);

   logic [hhdf_pkg::COUNT_W-1:0] mem [NUM_BINS];

   hhdf_pkg::op_type             op_ff;
   logic signed [CW-1:0]         x_ff, y_ff, z_ff;
   logic [IDX_W-1:0]             idx_ff;
   logic                         in_range_ff;
   logic [hhdf_pkg::COUNT_W-1:0] rd_ff;
   logic [IDX_W-1:0]             clr_ff;
   logic [hhdf_pkg::CSR_W-1:0]   thr_ff;
   logic signed [hhdf_pkg::CSR_W-1:0] base_ff;
   logic                         rsp_valid_ff;
   logic signed [CW-1:0]         out_x_ff, out_y_ff, out_z_ff;

   logic [MAG_W-1:0]             mag;
   logic [MAG_W-1:0]             rounded;
   logic signed [HGT_W-1:0]      height;
   logic signed [BIN_W-1:0]      bin;
   logic                         in_range;

   // Round height half away from zero, then offset by the base
   always_comb begin
      mag     = z_ff[CW-1] ? MAG_W'(-{z_ff[CW-1], z_ff}) : MAG_W'(z_ff);
      rounded = (mag + HALF) >> FRAC_BITS;
      height  = z_ff[CW-1] ? -$signed({1'b0, rounded}) : $signed({1'b0, rounded});
      bin     = BIN_W'(height) - BIN_W'(base_ff);
      in_range = !bin[BIN_W-1] && (bin[BIN_W-2:0] < (BIN_W-1)'(NUM_BINS));
   end

   // Capture the accepted item
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff <= req_op;
         x_ff  <= req_x;
         y_ff  <= req_y;
         z_ff  <= req_z;
      end
   end

   // Register the bin's range flag and index
   always_ff @(posedge clock) begin
      if (reset) in_range_ff <= 1'b0;
      else if (cmd.calc_bin) in_range_ff <= in_range;
   end

   always_ff @(posedge clock) begin
      if (cmd.calc_bin) idx_ff <= bin[IDX_W-1:0];
   end

   // Bin memory: clear sweep or increment, registered read
   always_ff @(posedge clock) begin
      if (cmd.clear_en) mem[clr_ff] <= '0;
      else if (cmd.write_bin) mem[idx_ff] <= rd_ff + 1'b1;
      if (cmd.read_bin) rd_ff <= mem[idx_ff];
   end

   // Advance the clear sweep
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_start) clr_ff <= '0;
      else if (cmd.clear_en) clr_ff <= clr_ff + 1'b1;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= hhdf_pkg::THRESHOLD_RESET;
         base_ff <= '0;
      end else if (csr_write) begin
         if (csr_index == hhdf_pkg::CSR_THRESHOLD) thr_ff <= csr_data;
         else base_ff <= $signed(csr_data);
      end
   end

   // Output register; drop valid on transfer
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.load_out) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_x_ff <= x_ff;
         out_y_ff <= y_ff;
         out_z_ff <= z_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_x     = out_x_ff;
   assign rsp_y     = out_y_ff;
   assign rsp_z     = out_z_ff;

   assign status.op         = op_ff;
   assign status.in_range   = in_range_ff;
   assign status.count_sat  = (rd_ff == hhdf_pkg::COUNT_MAX);
   assign status.keep       = (rd_ff > thr_ff);
   assign status.clear_last = (clr_ff == LAST_IDX);
   assign status.out_busy   = rsp_valid_ff && !rsp_ready;

endmodule

@@ sv/height_histogram_density_filter.sv @@
// Height histogram density filter.
// req channel carries points with an op: count (add the point to its height
// bin), filter (pass the point to rsp if its bin count exceeds the threshold)
// and clear (zero every bin). rsp channel carries the kept coordinates.
// csr port writes count_threshold (index 0) and height_base (index 1); write
// only while the block is idle.
// A count or filter point keeps req_ready low after its transfer through the
// bin index, bin memory read and update steps, so a new point is not taken
// before the last is through; the single-port bin memory read-modify-write
// sets this. A kept point appears on rsp in the cycle after the update. A
// clear keeps req_ready low after its transfer until the sweep, which zeroes
// one bin per cycle, has reached the last bin. Reset runs the same clearing
// sweep with req_ready low; csr writes are taken throughout.
// A stalled receiver leaves the kept point in the output register; further
// points are still taken, and a filter point that must be emitted waits in
// its update step until the register frees up.
module height_histogram_density_filter #(
   parameter int NUM_BINS  = 256,
   parameter int FRAC_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   hhdf_req_if.sink                      req_ch,
   hhdf_rsp_if.source                    rsp_ch,
   input  logic                          csr_write,
   input  logic                          csr_index,
   input  logic [hhdf_pkg::CSR_W-1:0]    csr_data
);

   hhdf_pkg::cmd_type    cmd;
   hhdf_pkg::status_type status;

   hhdf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_op    (req_ch.op),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   hhdf_datapath #(
      .NUM_BINS  (NUM_BINS),
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_op    (req_ch.op),
      .req_x     (req_ch.coord_x),
      .req_y     (req_ch.coord_y),
      .req_z     (req_ch.coord_z),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .rsp_x     (rsp_ch.kept_x),
      .rsp_y     (rsp_ch.kept_y),
      .rsp_z     (rsp_ch.kept_z)
   );

endmodule

@@ sim/tb_top.sv @@
module tb_top;

   localparam int NUM_BINS       = 256;
   localparam int FRAC_BITS      = 8;
   localparam int HEIGHT_STEP    = 1 << FRAC_BITS;
   localparam int ROUND_HALF     = HEIGHT_STEP >> 1;
   localparam int COORD_MAX      = (1 << (hhdf_pkg::COORD_W - 1)) - 1;
   localparam int COORD_MIN      = -(1 << (hhdf_pkg::COORD_W - 1));
   // one clear sweep plus the point pipeline, waited out before a csr write
   localparam int SETTLE_CYCLES  = NUM_BINS + 16;
   localparam int LONG_HOLD      = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int MAX_PRINTED    = 40;

   localparam hhdf_pkg::op_type OP_UNUSED = 2'd3;

   typedef logic signed [hhdf_pkg::COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   logic                       clock;
   logic                       reset;
   logic                       csr_write;
   logic                       csr_index;
   logic [hhdf_pkg::CSR_W-1:0] csr_data;

   hhdf_req_if req_ch ();
   hhdf_rsp_if rsp_ch ();

   height_histogram_density_filter #(
      .NUM_BINS  (NUM_BINS),
      .FRAC_BITS (FRAC_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Histogram copy and register shadows
   logic [hhdf_pkg::COUNT_W-1:0]      hist_count [NUM_BINS];
   logic [hhdf_pkg::CSR_W-1:0]        keep_threshold;
   logic signed [hhdf_pkg::CSR_W-1:0] zero_bin_height;
   point_type                         kept_points_due [$];

   bit tx_idle_en;
   bit rx_idle_en;
   bit rsp_hold_req = 1'b0;
   int rsp_stall_left = 0;
   int mismatch_count = 0;
   int kept_checked = 0;
   int quiet_cycles = 0;
   int op_sent [4] = '{0, 0, 0, 0};

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int height_units(input coord_type z);
      int mag;
      mag = (z < 0) ? -int'(z) : int'(z);
      mag = (mag + ROUND_HALF) >> FRAC_BITS;
      return (z < 0) ? -mag : mag;
   endfunction

   function automatic coord_type rand_coord();
      return coord_type'($urandom());
   endfunction

   function automatic coord_type to_coord(input int v);
      return coord_type'(v);
   endfunction

   // Pick a height that lands in bin k under the current base, exact halves now and then
   function automatic coord_type z_for_bin(input int k);
      int h;
      int z;
      h = int'(zero_bin_height) + k;
      if ($urandom_range(0, 7) == 0 && h != 0)
         z = h * HEIGHT_STEP + ((h > 0) ? -ROUND_HALF : ROUND_HALF);
      else
         z = h * HEIGHT_STEP + int'($urandom_range(0, 2 * ROUND_HALF - 2)) - (ROUND_HALF - 1);
      if (z > COORD_MAX)
         z = COORD_MAX;
      if (z < COORD_MIN)
         z = COORD_MIN;
      return coord_type'(z);
   endfunction

   task automatic report(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("MISMATCH at %0t: %s", $time, what);
   endtask

   // Update the histogram copy for one accepted point and queue a kept point
   task automatic apply_point(input hhdf_pkg::op_type op, input point_type pt);
      int  b;
      bit  in_range;
      b = height_units(pt.z) - int'(zero_bin_height);
      in_range = (b >= 0) && (b < NUM_BINS);
      case (op)
         hhdf_pkg::OP_CLEAR: begin
            foreach (hist_count[i])
               hist_count[i] = '0;
         end
         hhdf_pkg::OP_COUNT: begin
            if (in_range && hist_count[b] != hhdf_pkg::COUNT_MAX)
               hist_count[b] = hist_count[b] + 1'b1;
         end
         hhdf_pkg::OP_FILTER: begin
            if (in_range && hist_count[b] > keep_threshold)
               kept_points_due = {kept_points_due, pt};
         end
         default: ;
      endcase
   endtask

   // Offer one point after a random gap and hold it until the transfer
   task automatic send_point(input hhdf_pkg::op_type op, input coord_type x,
                             input coord_type y, input coord_type z);
      int        gap;
      point_type pt;
      gap = tx_idle_en ? $urandom_range(0, 7) : 0;
      pt.x = x;
      pt.y = y;
      pt.z = z;
      if (gap > 0) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid   <= 1'b1;
      req_ch.op      <= op;
      req_ch.coord_x <= x;
      req_ch.coord_y <= y;
      req_ch.coord_z <= z;
      do
         @(posedge clock);
      while (!req_ch.ready);
      apply_point(op, pt);
      op_sent[op]++;
   endtask

   // Drop valid, wait for every kept point, then let any clear sweep finish
   task automatic wait_idle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (kept_points_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [hhdf_pkg::CSR_W-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == hhdf_pkg::CSR_THRESHOLD)
         keep_threshold = value;
      else
         zero_bin_height = signed'(value);
   endtask

   // Clear, count a point cloud bunched in a few bins, then re-present it for filtering
   task automatic run_density_pass(input int n_points, input int hot_span);
      point_type counted [$];
      point_type p;
      int        hot_lo;
      int        pick;
      int        j;
      tx_idle_en = $urandom_range(0, 2) != 0;
      rx_idle_en = $urandom_range(0, 2) != 0;
      send_point(hhdf_pkg::OP_CLEAR, rand_coord(), rand_coord(), rand_coord());
      hot_lo = $urandom_range(0, NUM_BINS - hot_span);
      for (int i = 0; i < n_points; i++) begin
         pick = $urandom_range(0, 99);
         p.x = rand_coord();
         p.y = rand_coord();
         if (pick < 85)
            p.z = z_for_bin(hot_lo + $urandom_range(0, hot_span - 1));
         else if (pick < 93)
            p.z = z_for_bin(int'($urandom_range(0, NUM_BINS + 15)) - 8);
         else if (pick < 96)
            p.z = rand_coord();
         else begin
            // stray op in the counting pass
            pick = $urandom_range(0, 9);
            p.z = z_for_bin(hot_lo);
            if (pick == 0)
               send_point(hhdf_pkg::OP_CLEAR, p.x, p.y, p.z);
            else if (pick < 5)
               send_point(hhdf_pkg::OP_FILTER, p.x, p.y, p.z);
            else
               send_point(OP_UNUSED, p.x, p.y, p.z);
            continue;
         end
         counted = {counted, p};
         send_point(hhdf_pkg::OP_COUNT, p.x, p.y, p.z);
      end
      tx_idle_en = $urandom_range(0, 2) != 0;
      rx_idle_en = $urandom_range(0, 2) != 0;
      while (counted.size() > 0) begin
         j = $urandom_range(0, counted.size() - 1);
         p = counted[j];
         counted.delete(j);
         if ($urandom_range(0, 19) == 0)
            send_point(OP_UNUSED, rand_coord(), rand_coord(), p.z);
         send_point(hhdf_pkg::OP_FILTER, p.x, p.y, p.z);
      end
   endtask

   task automatic test_reset_defaults();
      run_density_pass(150, 3);
   endtask

   task automatic test_directed_edges();
      wait_idle();
      write_reg(hhdf_pkg::CSR_THRESHOLD, 16'd0);
      write_reg(hhdf_pkg::CSR_BASE, 16'd0);
      tx_idle_en = 1'b1;
      rx_idle_en = 1'b1;
      send_point(hhdf_pkg::OP_CLEAR, to_coord(0), to_coord(0), to_coord(0));
      // first and last bin, extreme x and y
      send_point(hhdf_pkg::OP_COUNT, to_coord(COORD_MAX), to_coord(COORD_MIN), to_coord(0));
      send_point(hhdf_pkg::OP_COUNT, to_coord(0), to_coord(0),
                 to_coord((NUM_BINS - 1) * HEIGHT_STEP + ROUND_HALF - 1));
      // just below bin zero and just past the last bin
      send_point(hhdf_pkg::OP_COUNT, to_coord(1), to_coord(2), to_coord(-ROUND_HALF));
      send_point(hhdf_pkg::OP_COUNT, to_coord(3), to_coord(4),
                 to_coord(NUM_BINS * HEIGHT_STEP - ROUND_HALF));
      // exact half rounds away from zero into bin one
      send_point(hhdf_pkg::OP_COUNT, to_coord(5), to_coord(6), to_coord(ROUND_HALF));
      // unused op must leave bin two empty
      send_point(OP_UNUSED, to_coord(7), to_coord(8), to_coord(2 * HEIGHT_STEP));
      send_point(hhdf_pkg::OP_FILTER, to_coord(COORD_MIN), to_coord(COORD_MAX),
                 to_coord(-(ROUND_HALF - 1)));
      send_point(hhdf_pkg::OP_FILTER, to_coord(COORD_MAX), to_coord(COORD_MAX),
                 to_coord((NUM_BINS - 1) * HEIGHT_STEP));
      send_point(hhdf_pkg::OP_FILTER, to_coord(COORD_MIN), to_coord(COORD_MIN),
                 to_coord(-ROUND_HALF));
      send_point(hhdf_pkg::OP_FILTER, to_coord(9), to_coord(10),
                 to_coord(NUM_BINS * HEIGHT_STEP - ROUND_HALF));
      send_point(hhdf_pkg::OP_FILTER, to_coord(11), to_coord(12),
                 to_coord(HEIGHT_STEP + ROUND_HALF - 1));
      send_point(hhdf_pkg::OP_FILTER, to_coord(13), to_coord(14), to_coord(2 * HEIGHT_STEP));
      send_point(hhdf_pkg::OP_CLEAR, to_coord(COORD_MAX), to_coord(COORD_MAX),
                 to_coord(COORD_MAX));
      send_point(hhdf_pkg::OP_FILTER, to_coord(15), to_coord(16), to_coord(0));
      // lowest base: the most negative height lands in bin zero
      wait_idle();
      write_reg(hhdf_pkg::CSR_BASE, 16'h8000);
      send_point(hhdf_pkg::OP_COUNT, to_coord(17), to_coord(18), to_coord(COORD_MIN));
      send_point(hhdf_pkg::OP_FILTER, to_coord(19), to_coord(20),
                 to_coord(COORD_MIN + HEIGHT_STEP - ROUND_HALF));
      // highest base: the top height rounds into bin one
      wait_idle();
      write_reg(hhdf_pkg::CSR_BASE, 16'h7FFF);
      send_point(hhdf_pkg::OP_COUNT, to_coord(21), to_coord(22), to_coord(COORD_MAX));
      send_point(hhdf_pkg::OP_FILTER, to_coord(23), to_coord(24), to_coord(COORD_MAX));
      send_point(hhdf_pkg::OP_FILTER, to_coord(25), to_coord(26),
                 to_coord(COORD_MAX - ROUND_HALF + 1));
      send_point(hhdf_pkg::OP_COUNT, to_coord(27), to_coord(28), to_coord(0));
   endtask

   task automatic test_output_backpressure();
      wait_idle();
      write_reg(hhdf_pkg::CSR_THRESHOLD, 16'd0);
      write_reg(hhdf_pkg::CSR_BASE, 16'd0);
      tx_idle_en = 1'b1;
      rx_idle_en = 1'b1;
      send_point(hhdf_pkg::OP_CLEAR, to_coord(0), to_coord(0), to_coord(0));
      for (int b = 0; b < 10; b++)
         send_point(hhdf_pkg::OP_COUNT, rand_coord(), rand_coord(), z_for_bin(b));
      wait_idle();
      // hold the receiver off while kept points arrive back to back
      rsp_hold_req = 1'b1;
      tx_idle_en = 1'b0;
      for (int i = 0; i < 30; i++)
         send_point(hhdf_pkg::OP_FILTER, rand_coord(), rand_coord(), z_for_bin(i % 10));
      // pause the sender until the backlog has drained
      wait_idle();
      tx_idle_en = 1'b1;
      for (int i = 0; i < 10; i++)
         send_point(hhdf_pkg::OP_FILTER, rand_coord(), rand_coord(), z_for_bin(9 - i));
   endtask

   task automatic test_threshold_limits();
      wait_idle();
      write_reg(hhdf_pkg::CSR_THRESHOLD, hhdf_pkg::COUNT_MAX);
      write_reg(hhdf_pkg::CSR_BASE, 16'd0);
      tx_idle_en = 1'b0;
      rx_idle_en = 1'b0;
      send_point(hhdf_pkg::OP_CLEAR, to_coord(0), to_coord(0), to_coord(0));
      repeat (60)
         send_point(hhdf_pkg::OP_COUNT, rand_coord(), rand_coord(), z_for_bin(5));
      // busy bin against the top threshold is never kept
      repeat (20)
         send_point(hhdf_pkg::OP_FILTER, rand_coord(), rand_coord(), z_for_bin(5));
      // count equal to the threshold is not kept, one above it is
      wait_idle();
      write_reg(hhdf_pkg::CSR_THRESHOLD, 16'd60);
      send_point(hhdf_pkg::OP_FILTER, to_coord(1), to_coord(1), z_for_bin(5));
      wait_idle();
      write_reg(hhdf_pkg::CSR_THRESHOLD, 16'd59);
      send_point(hhdf_pkg::OP_FILTER, to_coord(2), to_coord(2), z_for_bin(5));
      send_point(hhdf_pkg::OP_FILTER, to_coord(3), to_coord(3), z_for_bin(6));
   endtask

   task automatic test_random_passes();
      wait_idle();
      write_reg(hhdf_pkg::CSR_THRESHOLD, 16'd0);
      write_reg(hhdf_pkg::CSR_BASE, 16'h8000);
      run_density_pass(140, 4);
      wait_idle();
      write_reg(hhdf_pkg::CSR_THRESHOLD, 16'hFFFF);
      write_reg(hhdf_pkg::CSR_BASE, 16'h7FFF);
      run_density_pass(120, 2);
      wait_idle();
      write_reg(hhdf_pkg::CSR_THRESHOLD, 16'($urandom_range(1, 10)));
      write_reg(hhdf_pkg::CSR_BASE, 16'($urandom()));
      run_density_pass(140, 3);
      wait_idle();
      write_reg(hhdf_pkg::CSR_THRESHOLD, 16'd5);
      write_reg(hhdf_pkg::CSR_BASE, 16'hFF80);
      run_density_pass(140, 3);
      wait_idle();
      write_reg(hhdf_pkg::CSR_THRESHOLD, 16'($urandom_range(0, 3)));
      write_reg(hhdf_pkg::CSR_BASE, 16'(int'($urandom_range(0, 600)) - 300));
      run_density_pass(140, 6);
   endtask

   // Receiver pacing: long hold on request, else a random stall per transfer
   initial begin : rsp_pacing
      int hold_left;
      hold_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_req) begin
            hold_left = LONG_HOLD;
            rsp_hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (rsp_stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Compare each kept point with the oldest one due
   always @(posedge clock) begin : kept_check
      point_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_stall_left = rx_idle_en ? $urandom_range(0, 7) : 0;
         if (kept_points_due.size() == 0) begin
            report($sformatf("kept point with none due: x=%0d y=%0d z=%0d",
                             rsp_ch.kept_x, rsp_ch.kept_y, rsp_ch.kept_z));
         end else begin
            want = kept_points_due.pop_front();
            kept_checked++;
            if (rsp_ch.kept_x !== want.x)
               report($sformatf("kept_x %0d, expected %0d", rsp_ch.kept_x, want.x));
            if (rsp_ch.kept_y !== want.y)
               report($sformatf("kept_y %0d, expected %0d", rsp_ch.kept_y, want.y));
            if (rsp_ch.kept_z !== want.z)
               report($sformatf("kept_z %0d, expected %0d", rsp_ch.kept_z, want.z));
         end
      end
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin : watchdog
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || csr_write)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles, %0d kept points still due",
                  WATCHDOG_LIMIT, kept_points_due.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin : test_sequence
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.op      = hhdf_pkg::OP_COUNT;
      req_ch.coord_x = '0;
      req_ch.coord_y = '0;
      req_ch.coord_z = '0;
      csr_write      = 1'b0;
      csr_index      = hhdf_pkg::CSR_THRESHOLD;
      csr_data       = '0;
      tx_idle_en     = 1'b1;
      rx_idle_en     = 1'b1;
      foreach (hist_count[i])
         hist_count[i] = '0;
      keep_threshold  = hhdf_pkg::THRESHOLD_RESET;
      zero_bin_height = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_directed_edges();
      test_output_backpressure();
      test_threshold_limits();
      test_random_passes();
      wait_idle();

      if (kept_points_due.size() != 0)
         report($sformatf("%0d kept points never arrived", kept_points_due.size()));
      $display("Sent %0d count, %0d filter, %0d clear, %0d unused-op points; %0d kept checked",
               op_sent[hhdf_pkg::OP_COUNT], op_sent[hhdf_pkg::OP_FILTER],
               op_sent[hhdf_pkg::OP_CLEAR], op_sent[OP_UNUSED], kept_checked);
      $display("Thresholds 0 to 65535, bases -32768 to 32767, bin range edges, long rsp stall");
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
